[src/hex_record_to_binary_parser_top_defines.svh]
// assertion macros used by the checker file of the hex record parser
// no dependencies
`ifndef HEX_RECORD_TO_BINARY_PARSER_TOP_DEFINES_SVH
`define HEX_RECORD_TO_BINARY_PARSER_TOP_DEFINES_SVH

// checked only out of reset
`define HRBP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define HRBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/hrbp_pkg.sv]
// types, character codes and status codes of the hex record parser
// no dependencies
package hrbp_pkg;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [3:0] NIB_OFFSET = 4'd9;
    localparam logic [2:0] SKIP_CHARS = 3'd6;

    localparam logic [1:0] ST_DATA        = 2'd0;
    localparam logic [1:0] ST_NO_COLON    = 2'd1;
    localparam logic [1:0] ST_SHORT_COUNT = 2'd2;
    localparam logic [1:0] ST_SHORT_DATA  = 2'd3;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_CNT_HI = 3'd1,
        PH_CNT_LO = 3'd2,
        PH_SKIP   = 3'd3,
        PH_DAT_HI = 3'd4,
        PH_DAT_LO = 3'd5,
        PH_REST   = 3'd6
    } t_phase;

    typedef struct packed {
        logic       emit;
        logic [7:0] byte_value;
        logic [1:0] status;
    } t_result;

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [3:0] v;
        v = c[3:0];
        if (c >= CH_A) begin
            v = c[3:0] + NIB_OFFSET;
        end
        return v;
    endfunction

endpackage

[src/hrbp_decoder.sv]
// per-character record state machine of the hex record parser
// depends on hrbp_pkg
module hrbp_decoder
    import hrbp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_character,
    output t_result    o_res
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_remaining, n_remaining;
    logic [2:0] r_skip_left, n_skip_left;
    logic [3:0] r_high, n_high;
    logic       r_halted, n_halted;

    logic       eol;
    logic       live;
    logic [3:0] nib;
    logic [7:0] count_val;
    logic [7:0] rem_dec;
    logic [2:0] skip_dec;

    assign eol       = (i_character == CH_LF);
    assign live      = !r_halted && (i_character != CH_CR);
    assign nib       = nibble_of(i_character);
    assign count_val = {r_high, nib};
    assign rem_dec   = r_remaining - 8'd1;
    assign skip_dec  = r_skip_left - 3'd1;

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_skip_left = r_skip_left;
        n_high      = r_high;
        n_halted    = r_halted;
        if (live) begin
            case (r_phase)
                PH_START: begin
                    if (i_character != CH_COLON) begin
                        n_halted = 1'b1;
                    end else begin
                        n_phase = PH_CNT_HI;
                    end
                end
                PH_CNT_HI: begin
                    if (eol) begin
                        n_halted = 1'b1;
                    end else begin
                        n_high  = nib;
                        n_phase = PH_CNT_LO;
                    end
                end
                PH_CNT_LO: begin
                    if (eol) begin
                        n_halted = 1'b1;
                    end else begin
                        n_remaining = count_val;
                        if (count_val == 8'd0) begin
                            n_phase = PH_REST;
                        end else begin
                            n_skip_left = SKIP_CHARS;
                            n_phase     = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    if (eol) begin
                        n_halted = 1'b1;
                    end else begin
                        n_skip_left = skip_dec;
                        if (skip_dec == 3'd0) begin
                            n_phase = (r_remaining == 8'd0) ? PH_REST : PH_DAT_HI;
                        end
                    end
                end
                PH_DAT_HI: begin
                    if (eol) begin
                        n_halted = 1'b1;
                    end else begin
                        n_high  = nib;
                        n_phase = PH_DAT_LO;
                    end
                end
                PH_DAT_LO: begin
                    if (eol) begin
                        n_halted = 1'b1;
                    end else begin
                        n_remaining = rem_dec;
                        n_phase     = (rem_dec == 8'd0) ? PH_REST : PH_DAT_HI;
                    end
                end
                PH_REST: begin
                    if (eol) begin
                        n_phase = PH_START;
                    end
                end
                default: begin
                    n_phase = PH_START;
                end
            endcase
        end
    end

    // result for the current character
    always_comb begin
        o_res = '{emit: 1'b0, byte_value: 8'd0, status: ST_DATA};
        if (live) begin
            case (r_phase)
                PH_START: begin
                    if (i_character != CH_COLON) begin
                        o_res.emit   = 1'b1;
                        o_res.status = ST_NO_COLON;
                    end
                end
                PH_CNT_HI, PH_CNT_LO: begin
                    if (eol) begin
                        o_res.emit   = 1'b1;
                        o_res.status = ST_SHORT_COUNT;
                    end
                end
                PH_SKIP, PH_DAT_HI: begin
                    if (eol) begin
                        o_res.emit   = 1'b1;
                        o_res.status = ST_SHORT_DATA;
                    end
                end
                PH_DAT_LO: begin
                    o_res.emit = 1'b1;
                    if (eol) begin
                        o_res.status = ST_SHORT_DATA;
                    end else begin
                        o_res.byte_value = count_val;
                    end
                end
                default: begin
                    o_res.emit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_remaining <= 8'd0;
            r_skip_left <= 3'd0;
            r_high      <= 4'd0;
            r_halted    <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_skip_left <= n_skip_left;
            r_high      <= n_high;
            r_halted    <= n_halted;
        end
    end

endmodule

[src/hex_record_to_binary_parser_top.sv]
// Intel HEX text to binary byte stream parser, top level
// depends on hrbp_pkg and hrbp_decoder
//
// Input channel: one text character per word on i_character, valid/stall.
// Output channel: one word per data byte (o_status 0) or per error
// (o_status 1 missing colon, 2 short count, 3 short data, o_byte_value 0).
// A character is taken into an input register, decoded in the next cycle
// against the record state and, if it yields a word, moved into the output
// register. Throughput is one character per cycle while no stall backs
// up to the input, set by the record state update in the decoder.
// Characters that give no word (colon, count, address, checksum, CR) pass
// through without touching the output register, even while it is stalled.
// A stalled output word holds; stall then backs up to the input only when
// the waiting character also yields a word.
// After an error no further words appear until reset.
// Reset (synchronous, active low) empties both registers and returns the
// parser to awaiting a line start.
module hex_record_to_binary_parser_top
    import hrbp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_character,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_byte_value,
    output logic [1:0] o_status
);

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic [1:0] r_out_status;

    t_result    dec_res;
    logic       out_ready;
    logic       s1_move;

    hrbp_decoder u_decoder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (s1_move),
        .i_character (r_in_char),
        .o_res       (dec_res)
    );

    assign out_ready = !r_out_valid || !i_stall;
    assign s1_move   = r_in_valid && (!dec_res.emit || out_ready);
    assign o_stall   = r_in_valid && !s1_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (out_ready) begin
                r_out_valid <= s1_move && dec_res.emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_char <= i_character;
        end
        if (s1_move && dec_res.emit && out_ready) begin
            r_out_byte   <= dec_res.byte_value;
            r_out_status <= dec_res.status;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_byte_value = r_out_byte;
    assign o_status     = r_out_status;

endmodule

[src/hrbp_checker.sv]
// port-level checks of the hex record parser, bound to the top level
// depends on hrbp_pkg and hex_record_to_binary_parser_top_defines.svh
`include "hex_record_to_binary_parser_top_defines.svh"

module hrbp_checker
    import hrbp_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [7:0] i_character,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_byte_value,
    input logic [1:0] o_status
);

    logic out_take;
    logic in_take;

    assign out_take = o_valid && !i_stall;
    assign in_take  = i_valid && !o_stall;

    `HRBP_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "word valid after reset")

    `HRBP_ASSERT(a_error_zero, i_clk, i_rst_n, (o_valid && o_status != ST_DATA) |-> (o_byte_value == 8'd0), "error word with nonzero byte")

    `HRBP_ASSERT(a_halt_silent, i_clk, i_rst_n, (out_take && o_status != ST_DATA) |=> !o_valid, "word after error")

    `HRBP_ASSERT(a_stall_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_byte_value) && $stable(o_status)), "stalled word changed")

    // carriage return taken into an empty pipeline
    `HRBP_ASSERT(a_cr_silent, i_clk, i_rst_n, (in_take && i_character == CH_CR && !o_valid && $past(!i_valid && !o_stall)) |=> ##1 !o_valid, "carriage return gave a word")

endmodule

bind hex_record_to_binary_parser_top hrbp_checker u_hrbp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_character  (i_character),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_byte_value (o_byte_value),
    .o_status     (o_status)
);
